/* hdl/qsp_pkg.sv */
// ----------------------------------------------------------------------------
// qsp_pkg
// Shared types and constants for the quadrature servo PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package qsp_pkg;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_ERR_LIMIT = 3'd4,
    REG_PERIOD    = 3'd5,
    REG_CMD_MODE  = 3'd6,
    REG_PWM_SHIFT = 3'd7
  } qsp_reg_e;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // Reset values
  localparam logic [15:0] GainPRst    = 16'd1024;
  localparam logic [15:0] GainIRst    = 16'd0;
  localparam logic [15:0] GainDRst    = 16'd0;
  localparam logic [14:0] IntLimitRst = 15'd2047;
  localparam logic [14:0] ErrLimitRst = 15'd2000;
  localparam logic [15:0] PeriodRst   = 16'd100;
  localparam logic        CmdQuadRst  = 1'b1;
  localparam logic [3:0]  PwmShiftRst = 4'd6;

  // Drive clamp bounds
  localparam logic signed [15:0] DriveMax = 16'sh7fff;
  localparam logic signed [15:0] DriveMin = 16'sh8001;

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] int_limit;
    logic [14:0] err_limit;
    logic [15:0] period;
    logic        cmd_quad;
    logic [3:0]  pwm_shift;
  } qsp_cfg_t;

  // Registered PID terms handed from the tracking stage to the output stage
  typedef struct packed {
    logic signed [32:0] p_term;
    logic signed [32:0] i_term;
    logic signed [33:0] d_term;
    logic signed [15:0] err;
    logic               fault;
  } qsp_prod_t;

endpackage

`default_nettype wire

/* hdl/qsp_quad_dec.sv */
// ----------------------------------------------------------------------------
// qsp_quad_dec
// Gray-state quadrature step decoder: next phase and a -1/0/+1 count.
// ----------------------------------------------------------------------------
`default_nettype none

module qsp_quad_dec (
  input  wire logic [1:0]        phase_i,
  input  wire logic              a_i,
  input  wire logic              b_i,
  output logic [1:0]             phase_o,
  output logic signed [1:0]      delta_o
);

  always_comb begin
    phase_o = phase_i;
    delta_o = 2'sd0;
    unique case (phase_i)
      2'd0: begin
        if (a_i) begin
          phase_o = 2'd1; delta_o = 2'sd1;
        end else if (b_i) begin
          phase_o = 2'd3; delta_o = -2'sd1;
        end
      end
      2'd1: begin
        if (!a_i) begin
          phase_o = 2'd0; delta_o = -2'sd1;
        end else if (b_i) begin
          phase_o = 2'd2; delta_o = 2'sd1;
        end
      end
      2'd2: begin
        if (!a_i) begin
          phase_o = 2'd3; delta_o = 2'sd1;
        end else if (!b_i) begin
          phase_o = 2'd1; delta_o = -2'sd1;
        end
      end
      default: begin
        if (a_i) begin
          phase_o = 2'd2; delta_o = -2'sd1;
        end else if (!b_i) begin
          phase_o = 2'd0; delta_o = 2'sd1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/qsp_track.sv */
// ----------------------------------------------------------------------------
// qsp_track
// Decoders, position error, update timer, integral and registered products.
// ----------------------------------------------------------------------------
`default_nettype none

module qsp_track (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qsp_pkg::qsp_cfg_t cfg_i,
  input  wire logic              item_vld_i,
  input  wire logic              enc_a_i,
  input  wire logic              enc_b_i,
  input  wire logic              cmd_a_i,
  input  wire logic              cmd_b_i,
  output logic                   item_rdy_o,
  output logic                   prod_vld_o,
  output qsp_pkg::qsp_prod_t     prod_o,
  input  wire logic              prod_rdy_i
);
  import qsp_pkg::*;

  logic [1:0]         enc_ph_q, enc_ph_d, cmd_ph_q, cmd_ph_d;
  logic [1:0]         enc_qd_ph, cmd_qd_ph;
  logic signed [1:0]  enc_delta, cmd_qd_delta, cmd_delta;
  logic signed [15:0] pos_q, pos_d, int_q, int_d, prev_q;
  logic [15:0]        tick_q, tick_d;
  logic signed [17:0] pos_sum;
  logic signed [15:0] pos_sat, err;
  logic [16:0]        pos_abs;
  logic signed [16:0] nsum, diff;
  logic [17:0]        nsum_abs;
  logic               upd, fault, adv, vld_q;
  qsp_prod_t          prod_q, prod_d;

  qsp_quad_dec u_enc_dec (
    .phase_i (enc_ph_q),
    .a_i     (enc_a_i),
    .b_i     (enc_b_i),
    .phase_o (enc_qd_ph),
    .delta_o (enc_delta)
  );

  qsp_quad_dec u_cmd_dec (
    .phase_i (cmd_ph_q),
    .a_i     (cmd_a_i),
    .b_i     (cmd_b_i),
    .phase_o (cmd_qd_ph),
    .delta_o (cmd_qd_delta)
  );

  assign item_rdy_o = !vld_q || prod_rdy_i;
  assign adv        = item_vld_i && item_rdy_o;

  always_comb begin
    enc_ph_d = enc_qd_ph;
    if (cfg_i.cmd_quad) begin
      cmd_ph_d  = cmd_qd_ph;
      cmd_delta = cmd_qd_delta;
    end else begin
      // step/dir: count on falling step clock
      cmd_ph_d  = {1'b0, cmd_a_i};
      cmd_delta = ((cmd_ph_q != 2'd0) && !cmd_a_i) ? (cmd_b_i ? 2'sd1 : -2'sd1) : 2'sd0;
    end

    pos_sum = {{2{pos_q[15]}}, pos_q} + {{16{enc_delta[1]}}, enc_delta}
            + {{16{cmd_delta[1]}}, cmd_delta};
    if (pos_sum > 18'sd32767) begin
      pos_sat = 16'sh7fff;
    end else if (pos_sum < -18'sd32768) begin
      pos_sat = 16'sh8000;
    end else begin
      pos_sat = pos_sum[15:0];
    end

    upd    = (tick_q >= cfg_i.period);
    tick_d = upd ? 16'd1 : tick_q + 16'd1;

    pos_abs = pos_sat[15] ? 17'd0 - {1'b1, pos_sat} : {1'b0, pos_sat};
    fault   = (pos_abs >= {2'b00, cfg_i.err_limit});
    err     = fault ? 16'sd0 : pos_sat;
    pos_d   = upd ? err : pos_sat;

    nsum     = {int_q[15], int_q} + {err[15], err};
    nsum_abs = nsum[16] ? 18'd0 - {1'b1, nsum} : {1'b0, nsum};
    int_d    = (nsum_abs <= {3'b000, cfg_i.int_limit}) ? nsum[15:0] : int_q;

    diff = {prev_q[15], prev_q} - {err[15], err};

    prod_d.p_term = err * $signed({1'b0, cfg_i.gain_p});
    prod_d.i_term = int_d * $signed({1'b0, cfg_i.gain_i});
    prod_d.d_term = diff * $signed({1'b0, cfg_i.gain_d});
    prod_d.err    = err;
    prod_d.fault  = fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_ph_q <= 2'd0;
      cmd_ph_q <= 2'd0;
      pos_q    <= 16'sd0;
      int_q    <= 16'sd0;
      prev_q   <= 16'sd0;
      tick_q   <= 16'd0;
      vld_q    <= 1'b0;
    end else begin
      if (item_rdy_o) begin
        vld_q <= adv && upd;
      end
      if (adv) begin
        enc_ph_q <= enc_ph_d;
        cmd_ph_q <= cmd_ph_d;
        pos_q    <= pos_d;
        tick_q   <= tick_d;
        if (upd) begin
          int_q  <= int_d;
          prev_q <= err;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && upd) begin
      prod_q <= prod_d;
    end
  end

  assign prod_vld_o = vld_q;
  assign prod_o     = prod_q;

endmodule

`default_nettype wire

/* hdl/qsp_out.sv */
// ----------------------------------------------------------------------------
// qsp_out
// Sums the PID terms, clamps the drive, forms the PWM compare value.
// ----------------------------------------------------------------------------
`default_nettype none

module qsp_out (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 prod_vld_i,
  input  wire qsp_pkg::qsp_prod_t   prod_i,
  output logic                      prod_rdy_o,
  input  wire logic [3:0]           pwm_shift_i,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [qsp_pkg::OutDataW-1:0] m_axis_tdata
);
  import qsp_pkg::*;

  logic signed [35:0] acc;
  logic signed [15:0] drive;
  logic [15:0]        cmp;
  logic               vld_q;
  logic [OutDataW-1:0] data_q, data_d;

  assign prod_rdy_o = !vld_q || m_axis_tready;

  always_comb begin
    acc = {{3{prod_i.p_term[32]}}, prod_i.p_term}
        + {{3{prod_i.i_term[32]}}, prod_i.i_term}
        + {{2{prod_i.d_term[33]}}, prod_i.d_term};
    if (acc > 36'sd32767) begin
      drive = DriveMax;
    end else if (acc < -36'sd32767) begin
      drive = DriveMin;
    end else begin
      drive = acc[15:0];
    end
    // drive + 32768 never exceeds 16 bits after the clamp
    cmp    = {~drive[15], drive[14:0]} >> pwm_shift_i;
    data_d = {7'd0, prod_i.err, prod_i.fault, drive, cmp};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (prod_rdy_o) begin
      vld_q <= prod_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_vld_i && prod_rdy_o) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

/* hdl/quadrature_servo_pid.sv */
// Path: a pin sample that triggers a PID update goes through the input register, then the
//   tracking/multiply stage, then the output register, which holds its result.
// Throughput: one pin sample per cycle; each stage holds off only while its result is unread.
// Reset (rst_ni, async, active low): phases, error, integral, timer and valid bits clear;
//   configuration returns to its default values.
// ----------------------------------------------------------------------------
// quadrature_servo_pid
// Quadrature encoder position servo with PID drive and PWM compare output.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_servo_pid (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [qsp_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire logic [qsp_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // pin sample requests
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] enc_a, [1] enc_b, [2] cmd_a, [3] cmd_b, [7:4] zero
  input  wire logic [qsp_pkg::InDataW-1:0]       s_axis_tdata,
  // PID update results
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] pwm_compare, [31:16] drive, [32] limit_fault,
  // [48:33] error_seen, [55:49] zero
  output logic [qsp_pkg::OutDataW-1:0]           m_axis_tdata
);
  import qsp_pkg::*;

  qsp_cfg_t  cfg_q;
  logic      in_vld_q;
  logic [3:0] pins_q;
  logic      item_rdy, prod_vld, prod_rdy;
  qsp_prod_t prod;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= GainPRst;
      cfg_q.gain_i    <= GainIRst;
      cfg_q.gain_d    <= GainDRst;
      cfg_q.int_limit <= IntLimitRst;
      cfg_q.err_limit <= ErrLimitRst;
      cfg_q.period    <= PeriodRst;
      cfg_q.cmd_quad  <= CmdQuadRst;
      cfg_q.pwm_shift <= PwmShiftRst;
    end else if (cfg_we_i) begin
      unique case (qsp_reg_e'(cfg_addr_i))
        REG_GAIN_P:    cfg_q.gain_p    <= cfg_wdata_i;
        REG_GAIN_I:    cfg_q.gain_i    <= cfg_wdata_i;
        REG_GAIN_D:    cfg_q.gain_d    <= cfg_wdata_i;
        REG_INT_LIMIT: cfg_q.int_limit <= cfg_wdata_i[14:0];
        REG_ERR_LIMIT: cfg_q.err_limit <= cfg_wdata_i[14:0];
        REG_PERIOD:    cfg_q.period    <= cfg_wdata_i;
        REG_CMD_MODE:  cfg_q.cmd_quad  <= cfg_wdata_i[0];
        REG_PWM_SHIFT: cfg_q.pwm_shift <= cfg_wdata_i[3:0];
        default:       cfg_q.pwm_shift <= cfg_q.pwm_shift;
      endcase
    end
  end

  // Input register: frees up whenever the tracking stage takes the sample.
  assign s_axis_tready = !in_vld_q || item_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pins_q <= s_axis_tdata[3:0];
    end
  end

  // Decode, error tracking, update timer, integral and products.
  // Only samples that trigger an update move on to the output stage.
  qsp_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_vld_i (in_vld_q),
    .enc_a_i    (pins_q[0]),
    .enc_b_i    (pins_q[1]),
    .cmd_a_i    (pins_q[2]),
    .cmd_b_i    (pins_q[3]),
    .item_rdy_o (item_rdy),
    .prod_vld_o (prod_vld),
    .prod_o     (prod),
    .prod_rdy_i (prod_rdy)
  );

  // Term sum, drive clamp, PWM compare and the result register.
  qsp_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .prod_vld_i    (prod_vld),
    .prod_i        (prod),
    .prod_rdy_o    (prod_rdy),
    .pwm_shift_i   (cfg_q.pwm_shift),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* sim/qsp_servo_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_servo_checker
// Follows register writes and accepted pin samples of the servo block. It
// predicts each PID update on its own and compares the updates that the block
// emits, field by field and in order.
// ----------------------------------------------------------------------------
module qsp_servo_checker
  import qsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Same layout as the result bus, lowest field last
  typedef struct packed {
    logic signed [15:0] err_seen;
    logic               limit_fault;
    logic signed [15:0] drive;
    logic        [15:0] pwm_compare;
  } servo_update_t;

  // Decoder step: new phase, and the move as a 2-bit two's complement value
  typedef struct packed {
    logic        [1:0] phase;
    logic signed [1:0] delta;
  } gray_move_t;

  qsp_cfg_t      cfg;
  logic [1:0]    enc_phase;
  logic [1:0]    cmd_phase;
  int            pos_err;
  int            integ;
  int            prev_err;
  int            ticks;
  servo_update_t updates_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: servo update %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic gray_move_t gray_decode(input logic [1:0] ph, input logic a,
                                             input logic b);
    gray_move_t m;
    m = {ph, 2'b00};
    case (ph)
      2'd0: begin
        if (a) m = {2'd1, 2'b01};
        else if (b) m = {2'd3, 2'b11};
      end
      2'd1: begin
        if (!a) m = {2'd0, 2'b11};
        else if (b) m = {2'd2, 2'b01};
      end
      2'd2: begin
        if (!a) m = {2'd3, 2'b01};
        else if (!b) m = {2'd1, 2'b11};
      end
      default: begin
        if (a) m = {2'd2, 2'b11};
        else if (!b) m = {2'd0, 2'b01};
      end
    endcase
    return m;
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // One pin sample: decode both sides, track the error, and on a period
  // boundary queue the PID update that the block owes
  task automatic predict_servo_tick(input logic [InDataW-1:0] pins);
    gray_move_t    mv;
    int            delta;
    int            e;
    int            nsum;
    int            drive;
    int            cmp;
    longint        acc;
    logic          fault;
    servo_update_t u;
    mv        = gray_decode(enc_phase, pins[0], pins[1]);
    enc_phase = mv.phase;
    delta     = $signed(mv.delta);
    if (cfg.cmd_quad) begin
      mv        = gray_decode(cmd_phase, pins[2], pins[3]);
      cmd_phase = mv.phase;
      delta     = delta + $signed(mv.delta);
    end else begin
      // step/dir: count on the falling step edge, any nonzero phase is high
      if (cmd_phase != 2'd0 && !pins[2]) delta = delta + (pins[3] ? 1 : -1);
      cmd_phase = {1'b0, pins[2]};
    end
    e = pos_err + delta;
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    pos_err = e;

    if (ticks < int'(cfg.period)) begin
      ticks = ticks + 1;
    end else begin
      ticks = 1;
      fault = (magnitude(pos_err) >= int'(cfg.err_limit));
      if (fault) pos_err = 0;
      e    = pos_err;
      nsum = integ + e;
      if (magnitude(nsum) <= int'(cfg.int_limit)) integ = nsum;
      acc = longint'(e) * longint'(cfg.gain_p)
          + longint'(integ) * longint'(cfg.gain_i)
          + longint'(prev_err - e) * longint'(cfg.gain_d);
      prev_err = e;
      if (acc > longint'(DriveMax)) acc = longint'(DriveMax);
      if (acc < longint'(DriveMin)) acc = longint'(DriveMin);
      drive = int'(acc);
      cmp   = (drive + 32768) >> cfg.pwm_shift;
      u.pwm_compare = cmp[15:0];
      u.drive       = drive[15:0];
      u.limit_fault = fault;
      u.err_seen    = e[15:0];
      updates_q.push_back(u);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    servo_update_t got;
    servo_update_t want;
    if (!rst_ni) begin
      cfg.gain_p    = GainPRst;
      cfg.gain_i    = GainIRst;
      cfg.gain_d    = GainDRst;
      cfg.int_limit = IntLimitRst;
      cfg.err_limit = ErrLimitRst;
      cfg.period    = PeriodRst;
      cfg.cmd_quad  = CmdQuadRst;
      cfg.pwm_shift = PwmShiftRst;
      enc_phase = 2'd0;
      cmd_phase = 2'd0;
      pos_err   = 0;
      integ     = 0;
      prev_err  = 0;
      ticks     = 0;
      updates_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (qsp_reg_e'(cfg_addr_i))
          REG_GAIN_P:    cfg.gain_p    = cfg_wdata_i;
          REG_GAIN_I:    cfg.gain_i    = cfg_wdata_i;
          REG_GAIN_D:    cfg.gain_d    = cfg_wdata_i;
          REG_INT_LIMIT: cfg.int_limit = cfg_wdata_i[14:0];
          REG_ERR_LIMIT: cfg.err_limit = cfg_wdata_i[14:0];
          REG_PERIOD:    cfg.period    = cfg_wdata_i;
          REG_CMD_MODE:  cfg.cmd_quad  = cfg_wdata_i[0];
          REG_PWM_SHIFT: cfg.pwm_shift = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[$bits(servo_update_t)-1:0];
        if (updates_q.size() == 0) begin
          report_mismatch("with none pending, drive", got.drive, 0);
        end else begin
          want = updates_q.pop_front();
          if (got.pwm_compare !== want.pwm_compare)
            report_mismatch("pwm_compare", got.pwm_compare, want.pwm_compare);
          if (got.drive !== want.drive)
            report_mismatch("drive", got.drive, want.drive);
          if (got.limit_fault !== want.limit_fault)
            report_mismatch("limit_fault", got.limit_fault, want.limit_fault);
          if (got.err_seen !== want.err_seen)
            report_mismatch("error_seen", got.err_seen, want.err_seen);
        end
      end
      if (in_valid_i && in_ready_i) predict_servo_tick(in_data_i);
    end
    pending_o = updates_q.size();
  end

endmodule

/* sim/quadrature_servo_pid_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_servo_pid_tb
// Drives pin samples into the servo block over the sample stream and drains
// its PID updates, under several register settings and flow-control patterns.
// A checker beside the block predicts every update; this module only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module quadrature_servo_pid_tb;
  import qsp_pkg::*;

  localparam int ClkHalfNs    = 5;
  localparam int DrainCycles  = 8;        // pipeline is 3 deep, leave margin
  localparam int HoldCycles   = 200;      // long receiver back-pressure
  localparam int RandPhases   = 8;
  localparam int PhaseItems   = 50;       // 8 x 50 random requests
  localparam int SweepItems   = 20;       // +-2 per tick over a long period
  localparam int TimeoutNs    = 10_000_000;

  // Directed nibbles {cmd_b, cmd_a, enc_b, enc_a}, first request lowest.
  // Quadrature: encoder walk both ways with a skipped state, then command walk.
  localparam int          QuadLen = 14;
  localparam logic [55:0] QuadSeq = 56'hF808C420130231;
  // Step/dir: first low step level right after the mode switch counts, both
  // directions, encoder moving at the same time.
  localparam int          StepLen = 10;
  localparam logic [39:0] StepSeq = 40'h37F9DBF373;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int pending_updates;

  // flow control knobs, percent of cycles
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_kick  = 1'b0;   // toggled to start a long hold-off
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;

  // pin generator state
  qsp_cfg_t cur_cfg;
  int       enc_pos = 0;
  int       cmd_pos = 0;
  int       enc_dir = 1;
  int       cmd_dir = 1;
  logic     step_clk = 1'b0;
  logic     step_dir = 1'b0;

  always #ClkHalfNs clk_i = ~clk_i;

  quadrature_servo_pid u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] enc_a, [1] enc_b, [2] cmd_a, [3] cmd_b
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [15:0] pwm, [31:16] drive, [32] fault, [48:33] err
  );

  qsp_servo_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_updates)
  );

  // Result side. Random stalls at stall_pct; a kick from the stimulus holds
  // tready low for HoldCycles, counted here so the sender keeps going.
  always @(negedge clk_i) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Safety net against a hung handshake
  initial begin : watchdog
    #(TimeoutNs);
    $display("quadrature_servo_pid_tb: FAIL");
    $finish;
  end

  // Gray code pins {b, a} for a quadrature position 0..3
  function automatic logic [1:0] gray_pins(input int pos);
    return {(pos == 2 || pos == 3), (pos == 1 || pos == 2)};
  endfunction

  function automatic qsp_cfg_t make_cfg(input int gp, input int gi, input int gd,
                                        input int il, input int el, input int per,
                                        input logic quad, input int sh);
    qsp_cfg_t c;
    c.gain_p    = gp[15:0];
    c.gain_i    = gi[15:0];
    c.gain_d    = gd[15:0];
    c.int_limit = il[14:0];
    c.err_limit = el[14:0];
    c.period    = per[15:0];
    c.cmd_quad  = quad;
    c.pwm_shift = sh[3:0];
    return c;
  endfunction

  function automatic int random_gain();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(4095);
    endcase
  endfunction

  // Extremes show up often; periods are mostly short so updates are frequent
  function automatic qsp_cfg_t random_settings();
    int il;
    int el;
    int per;
    case ($urandom_range(3))
      0:       il = 0;
      1:       il = 32767;
      default: il = $urandom_range(3000);
    endcase
    case ($urandom_range(3))
      0:       el = 1;
      1:       el = 32767;
      default: el = $urandom_range(300, 2);
    endcase
    per = ($urandom_range(9) == 0) ? 65535 : $urandom_range(6, 1);
    return make_cfg(random_gain(), random_gain(), random_gain(), il, el, per,
                    1'($urandom_range(1)), $urandom_range(8));
  endfunction

  // Write all eight registers back to back; only called with the block idle
  task automatic apply_settings(input qsp_cfg_t c);
    qsp_reg_e idx;
    int       k;
    cur_cfg = c;
    for (k = 0; k < 8; k++) begin
      idx = qsp_reg_e'(k);
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= idx;
      case (idx)
        REG_GAIN_P:    cfg_wdata_i <= c.gain_p;
        REG_GAIN_I:    cfg_wdata_i <= c.gain_i;
        REG_GAIN_D:    cfg_wdata_i <= c.gain_d;
        REG_INT_LIMIT: cfg_wdata_i <= {1'b0, c.int_limit};
        REG_ERR_LIMIT: cfg_wdata_i <= {1'b0, c.err_limit};
        REG_PERIOD:    cfg_wdata_i <= c.period;
        REG_CMD_MODE:  cfg_wdata_i <= {15'd0, c.cmd_quad};
        REG_PWM_SHIFT: cfg_wdata_i <= {12'd0, c.pwm_shift};
        default:       cfg_wdata_i <= '0;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offer one pin-sample request; returns at the falling edge after it is taken
  task automatic push_sample(input logic [InDataW-1:0] pins);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pins;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop sending, wait out every pending update, then let samples that owe
  // no update leave the pipe too
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_updates != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Mostly legal Gray walks with random speed and direction reversals; a few
  // skipped states and raw pin noise to break the sequences
  task automatic next_pins(output logic [InDataW-1:0] pins);
    int         r;
    logic [1:0] cp;
    r = $urandom_range(99);
    if ($urandom_range(15) == 0) enc_dir = -enc_dir;
    if ($urandom_range(15) == 0) cmd_dir = -cmd_dir;
    if (r < 10) begin
      pins = InDataW'($urandom_range(15));
    end else begin
      if (r < 15) enc_pos = (enc_pos + 2) & 3;
      else if ($urandom_range(3) != 0) enc_pos = (enc_pos + enc_dir) & 3;
      if (cur_cfg.cmd_quad) begin
        if ($urandom_range(3) != 0) cmd_pos = (cmd_pos + cmd_dir) & 3;
        cp = gray_pins(cmd_pos);
      end else begin
        if ($urandom_range(1) != 0) step_clk = ~step_clk;
        if ($urandom_range(7) == 0) step_dir = ~step_dir;
        cp = {step_dir, step_clk};
      end
      pins = {4'b0000, cp, gray_pins(enc_pos)};
    end
  endtask

  initial begin : stimulus
    qsp_cfg_t           c;
    logic [InDataW-1:0] pins;
    int                 ph;
    int                 k;
    int                 sweep;
    int                 stride;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, quadrature command: update on every tick after the first, zero integral limit
    // (integral frozen unless the new sum is zero), small fault threshold
    apply_settings(make_cfg(1024, 100, 300, 0, 3, 1, 1'b1, 0));
    for (k = 0; k < QuadLen; k++) push_sample({4'b0000, QuadSeq[4*k +: 4]});

    // Directed, step/dir with all gains at maximum so the drive clamps,
    // widest limits and a PWM shift of 8
    settle();
    apply_settings(make_cfg(65535, 65535, 65535, 32767, 32767, 1, 1'b0, 8));
    for (k = 0; k < StepLen; k++) push_sample({4'b0000, StepSeq[4*k +: 4]});
    enc_pos = 1;

    // Random phases, cycling through the four flow-control patterns
    for (ph = 0; ph < RandPhases; ph++) begin
      c = random_settings();
      if (ph == 2) c.period = 1;   // every request yields an update
      settle();
      apply_settings(c);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      // long hold-off while the sender keeps offering: the pipe fills and
      // the block stalls its input
      if (ph == 2) hold_kick = ~hold_kick;
      for (k = 0; k < PhaseItems; k++) begin
        if (ph == 5 && k == PhaseItems / 2) settle();   // sender waits for all updates
        next_pins(pins);
        push_sample(pins);
      end
    end

    // Steady run in both directions: long period so no update interrupts the
    // run while the error moves two counts per tick, then period 1 (below the
    // running count) forces an update on the next tick.
    idle_pct  = 0;
    stall_pct = 0;
    for (sweep = 0; sweep < 2; sweep++) begin
      c = make_cfg(65535, 0, 0, 32767, 32767, 65535, 1'b1, 4);
      settle();
      apply_settings(c);
      stride = (sweep == 0) ? 1 : 3;
      repeat (SweepItems) begin
        enc_pos = (enc_pos + stride) & 3;
        cmd_pos = (cmd_pos + stride) & 3;
        push_sample({4'b0000, gray_pins(cmd_pos), gray_pins(enc_pos)});
      end
      c.period = 1;
      settle();
      apply_settings(c);
      repeat (4) push_sample({4'b0000, gray_pins(cmd_pos), gray_pins(enc_pos)});
    end

    settle();
    if (fail_count == 0 && pending_updates == 0) begin
      $display("quadrature_servo_pid_tb: PASS");
    end else begin
      $display("quadrature_servo_pid_tb: FAIL");
    end
    $finish;
  end

endmodule
